// File: rtl/mh_pkg.sv
package mh_pkg;

    // field and result widths
    localparam int FIELD_W         = 16;
    localparam int BYTE_W          = 8;
    localparam int HEAD_W          = 15;
    localparam int ANGLE_FRAC_BITS = 6;

    // cordic datapath
    localparam int CORDIC_STEPS = 24;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int PRESCALE_SH  = 20;
    localparam int XY_W         = FIELD_W + PRESCALE_SH + 2;
    localparam int Z_W          = 35;
    localparam int ATAN_W       = 30;

    localparam logic signed [Z_W-1:0] PI_RAD30     = 35'sd3373259426;
    localparam logic signed [Z_W-1:0] TWO_PI_RAD30 = 35'sd6746518853;

    // radians to degrees, digit-serial multiply
    localparam int          DEG_W        = 30;
    localparam logic [DEG_W-1:0] DEG_PER_RAD_Q24 = 30'd961263669;
    localparam int          Z_DIG_W      = 4;
    localparam int          Z_DIGITS     = 9;
    localparam int          ZSH_W        = Z_DIG_W * Z_DIGITS;
    localparam int          MCNT_W       = $clog2(Z_DIGITS);
    localparam int          ACC_W        = 35;
    localparam int          PROD_SH      = 54 - ANGLE_FRAC_BITS;
    localparam int          RND_SH       = PROD_SH - ZSH_W;
    localparam int          UNITS_W      = 20;
    localparam logic [UNITS_W-1:0] TURN  = UNITS_W'(360) << ANGLE_FRAC_BITS;

    // request and result payloads
    typedef struct packed {
        logic              read_complete;
        logic [BYTE_W-1:0] x_high;
        logic [BYTE_W-1:0] x_low;
        logic [BYTE_W-1:0] z_high;
        logic [BYTE_W-1:0] z_low;
        logic [BYTE_W-1:0] y_high;
        logic [BYTE_W-1:0] y_low;
    } t_mh_req;

    typedef struct packed {
        logic                      heading_ok;
        logic [HEAD_W-1:0]         heading_deg;
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
    } t_mh_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_FOLD,
        S_MUL,
        S_ROUND,
        S_DONE
    } t_mh_state;

    // atan(2^-i) in radians scaled by 2^30
    function automatic logic [ATAN_W-1:0] atan_rad30(input logic [STEP_W-1:0] step);
        logic [ATAN_W-1:0] v;
        case (step)
            5'd0:    v = 30'h3243F6A8;
            5'd1:    v = 30'h1DAC6705;
            5'd2:    v = 30'h0FADBAFC;
            5'd3:    v = 30'h07F56EA6;
            5'd4:    v = 30'h03FEAB76;
            5'd5:    v = 30'h01FFD55B;
            5'd6:    v = 30'h00FFFAAA;
            5'd7:    v = 30'h007FFF55;
            5'd8:    v = 30'h003FFFEA;
            5'd9:    v = 30'h001FFFFD;
            5'd10:   v = 30'h000FFFFF;
            5'd11:   v = 30'h0007FFFF;
            5'd12:   v = 30'h0003FFFF;
            5'd13:   v = 30'h0001FFFF;
            5'd14:   v = 30'h0000FFFF;
            5'd15:   v = 30'h00007FFF;
            5'd16:   v = 30'h00003FFF;
            5'd17:   v = 30'h00001FFF;
            5'd18:   v = 30'h00000FFF;
            5'd19:   v = 30'h000007FF;
            5'd20:   v = 30'h000003FF;
            5'd21:   v = 30'h000001FF;
            5'd22:   v = 30'h000000FF;
            5'd23:   v = 30'h0000007F;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/mh_req_if.sv
interface mh_req_if import mh_pkg::*; ();
    logic    valid;
    logic    ready;
    t_mh_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/mh_res_if.sv
interface mh_res_if import mh_pkg::*; ();
    logic    valid;
    logic    ready;
    t_mh_res data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/magnetometer_heading.sv
// Compass heading from one magnetometer burst read.
// i_req carries one request: the six raw bytes in device order and a
// read-complete flag. o_res returns one result per request: heading_ok,
// the heading in degrees with 6 fraction bits (0 up to just under 360),
// and the stored X, Y and Z field values.
// A complete read updates the stored fields and runs a 24-step CORDIC
// (one iteration per cycle), a fold into one turn, and a 4-bit-per-cycle
// serial multiply that turns radians into degrees, then rounds. A new
// request is taken only once the block is back in idle after the last
// result is loaded into the output register, so requests do not
// overlap. The time taken is set by the CORDIC iterations and the 9
// multiply digits. An incomplete read, or X and Y both zero, skips the
// arithmetic and goes straight to the final state to load its result.
// The block holds one request at a time; the result sits in an output
// register, so a request can be accepted while the last result waits.
// A stalled receiver holds the result and, once the next request is done,
// the block waits in its final state until the register is free.
// Reset (synchronous, active low) clears the stored fields to zero and
// empties the output register.
module magnetometer_heading import mh_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    mh_req_if.sink   i_req,
    mh_res_if.source o_res
);

    t_mh_state r_state, n_state;

    logic signed [XY_W-1:0]    r_x, r_y;
    logic signed [Z_W-1:0]     r_z;
    logic [STEP_W-1:0]         r_step;
    logic [ZSH_W-1:0]          r_zsh;
    logic [ACC_W-1:0]          r_acc;
    logic [MCNT_W-1:0]         r_cnt;
    logic                      r_ok;
    logic [HEAD_W-1:0]         r_head;
    logic signed [FIELD_W-1:0] r_fx, r_fy, r_fz;
    logic                      r_ovalid;
    t_mh_res                   r_res;

    logic w_in_ready, w_in_fire, w_res_load, w_zero;
    logic signed [FIELD_W-1:0] w_fx, w_fy, w_fz;
    logic signed [XY_W-1:0]    w_x0, w_y0, w_xs, w_ys;
    logic signed [Z_W-1:0]     w_atan, w_z1, w_z2, w_z3;
    logic [ACC_W-1:0]          w_prod, w_accsum, w_rnd;
    logic [UNITS_W-1:0]        w_units, w_units_f;

    // shift right rounding toward zero
    function automatic logic signed [XY_W-1:0] shr_tz(
        input logic signed [XY_W-1:0] v,
        input logic [STEP_W-1:0]      s
    );
        logic [XY_W-1:0] mask;
        mask = ~({XY_W{1'b1}} << s);
        return v[XY_W-1] ? ((v + $signed(mask)) >>> s) : (v >>> s);
    endfunction

    // request unpacking
    always_comb begin
        w_fx   = $signed({i_req.data.x_high, i_req.data.x_low});
        w_fy   = $signed({i_req.data.y_high, i_req.data.y_low});
        w_fz   = $signed({i_req.data.z_high, i_req.data.z_low});
        w_zero = (w_fx == '0) && (w_fy == '0);
        w_x0   = {{(XY_W-FIELD_W){w_fx[FIELD_W-1]}}, w_fx};
        w_y0   = {{(XY_W-FIELD_W){w_fy[FIELD_W-1]}}, w_fy};
        if (w_fx[FIELD_W-1]) begin
            w_x0 = -w_x0;
            w_y0 = -w_y0;
        end
        w_x0 = w_x0 <<< PRESCALE_SH;
        w_y0 = w_y0 <<< PRESCALE_SH;
    end

    // cordic iteration terms
    always_comb begin
        w_xs   = shr_tz(r_x, r_step);
        w_ys   = shr_tz(r_y, r_step);
        w_atan = $signed({{(Z_W-ATAN_W){1'b0}}, atan_rad30(r_step)});
    end

    // fold angle into one turn
    always_comb begin
        w_z1 = (r_z < 0) ? (r_z + TWO_PI_RAD30) : r_z;
        w_z2 = (w_z1 < 0) ? '0 : w_z1;
        w_z3 = (w_z2 >= TWO_PI_RAD30) ? (w_z2 - TWO_PI_RAD30) : w_z2;
    end

    // serial multiply digit and final rounding
    always_comb begin
        w_prod    = ACC_W'(r_zsh[Z_DIG_W-1:0]) * ACC_W'(DEG_PER_RAD_Q24);
        w_accsum  = r_acc + w_prod;
        w_rnd     = (r_acc + (ACC_W'(1) << (RND_SH - 1))) >> RND_SH;
        w_units   = w_rnd[UNITS_W-1:0];
        w_units_f = (w_units >= TURN) ? (w_units - TURN) : w_units;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_state = (!i_req.data.read_complete || w_zero) ? S_DONE : S_ROT;
                end
            end
            S_ROT: begin
                if (r_step == STEP_W'(CORDIC_STEPS - 1)) begin
                    n_state = S_FOLD;
                end
            end
            S_FOLD:  n_state = S_MUL;
            S_MUL: begin
                if (r_cnt == MCNT_W'(Z_DIGITS - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = S_DONE;
            S_DONE: begin
                if (w_res_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        w_in_ready = (r_state == S_IDLE);
        w_in_fire  = w_in_ready && i_req.valid;
        w_res_load = (r_state == S_DONE) && (!r_ovalid || o_res.ready);
    end

    assign i_req.ready = w_in_ready;
    assign o_res.valid = r_ovalid;
    assign o_res.data  = r_res;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_fx     <= '0;
            r_fy     <= '0;
            r_fz     <= '0;
        end else begin
            r_state <= n_state;
            if (w_res_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (w_in_fire && i_req.data.read_complete) begin
                r_fx <= w_fx;
                r_fy <= w_fy;
                r_fz <= w_fz;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_ok   <= i_req.data.read_complete;
            r_head <= '0;
            r_x    <= w_x0;
            r_y    <= w_y0;
            r_z    <= w_fx[FIELD_W-1] ? PI_RAD30 : '0;
            r_step <= '0;
        end
        if (r_state == S_ROT) begin
            if (r_y > 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
            r_step <= r_step + STEP_W'(1);
        end
        if (r_state == S_FOLD) begin
            r_zsh <= ZSH_W'($unsigned(w_z3));
            r_acc <= '0;
            r_cnt <= '0;
        end
        if (r_state == S_MUL) begin
            r_acc <= w_accsum >> Z_DIG_W;
            r_zsh <= r_zsh >> Z_DIG_W;
            r_cnt <= r_cnt + MCNT_W'(1);
        end
        if (r_state == S_ROUND) begin
            r_head <= w_units_f[HEAD_W-1:0];
        end
        if (w_res_load) begin
            r_res.heading_ok  <= r_ok;
            r_res.heading_deg <= r_head;
            r_res.field_x     <= r_fx;
            r_res.field_y     <= r_fy;
            r_res.field_z     <= r_fz;
        end
    end

    // checks
    a_head_in_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (UNITS_W'(o_res.data.heading_deg) < TURN))
        else $error("heading beyond one turn");

    a_bad_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.heading_ok) |-> (o_res.data.heading_deg == '0))
        else $error("incomplete read with nonzero heading");

    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != S_IDLE))
        else $error("request accepted but block idle");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FOLD) |=> (r_zsh < ZSH_W'($unsigned(TWO_PI_RAD30))))
        else $error("folded angle out of range");

endmodule

// File: tb/tb_magnetometer_heading.sv
module tb_magnetometer_heading;
    import mh_pkg::*;

    localparam int       RANDOM_READS    = 1930;
    localparam int       HOLD_OFF_CYCLES = 400;
    localparam int       IDLE_LIMIT      = 3000;
    localparam int       DRAIN_CYCLES    = 60;
    localparam longint   FIELD_PRESCALE  = 64'sd1 << PRESCALE_SH;
    localparam longint   FULL_TURN       = 64'sd360 << ANGLE_FRAC_BITS;

    // atan(2^-i) in radians, scaled by 2^30
    localparam longint ATAN_Q30 [CORDIC_STEPS] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // stored field copy and the headings still owed by the block
    class heading_tracker;
        logic signed [FIELD_W-1:0] stored_x;
        logic signed [FIELD_W-1:0] stored_y;
        logic signed [FIELD_W-1:0] stored_z;
        t_mh_res                   owed_headings[$];
        int                        errors;

        function new();
            stored_x = '0;
            stored_y = '0;
            stored_z = '0;
            errors   = 0;
        endfunction

        // shift that truncates toward zero
        function longint shift_toward_zero(longint v, int s);
            return (v < 0) ? -((-v) >>> s) : (v >>> s);
        endfunction

        // vectoring cordic, then radians to degrees with rounding
        function logic [HEAD_W-1:0] cordic_heading(logic signed [FIELD_W-1:0] fx,
                                                   logic signed [FIELD_W-1:0] fy);
            longint x;
            longint y;
            longint z;
            longint nx;
            longint unsigned units;
            if (fx == 0 && fy == 0) begin
                return '0;
            end
            x = fx;
            y = fy;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = PI_RAD30;
            end
            x = x * FIELD_PRESCALE;
            y = y * FIELD_PRESCALE;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                if (y > 0) begin
                    nx = x + shift_toward_zero(y, i);
                    y  = y - shift_toward_zero(x, i);
                    z  = z + ATAN_Q30[i];
                end else begin
                    nx = x - shift_toward_zero(y, i);
                    y  = y + shift_toward_zero(x, i);
                    z  = z - ATAN_Q30[i];
                end
                x = nx;
            end
            // fold into one turn
            if (z < 0) z = z + TWO_PI_RAD30;
            if (z < 0) z = 0;
            if (z >= TWO_PI_RAD30) z = z - TWO_PI_RAD30;
            units = (longint'(z) * longint'(DEG_PER_RAD_Q24)
                     + (64'd1 << (53 - ANGLE_FRAC_BITS))) >> (54 - ANGLE_FRAC_BITS);
            if (units >= FULL_TURN) units = units - FULL_TURN;
            return HEAD_W'(units);
        endfunction

        function void note_read(t_mh_req r);
            t_mh_res e;
            if (r.read_complete) begin
                stored_x = {r.x_high, r.x_low};
                stored_z = {r.z_high, r.z_low};
                stored_y = {r.y_high, r.y_low};
            end
            e.heading_ok  = r.read_complete;
            e.heading_deg = r.read_complete ? cordic_heading(stored_x, stored_y) : '0;
            e.field_x     = stored_x;
            e.field_y     = stored_y;
            e.field_z     = stored_z;
            owed_headings.push_back(e);
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_heading(t_mh_res got);
            t_mh_res e;
            int      diff;
            bit      near;
            if (owed_headings.size() == 0) begin
                $error("unexpected result: heading_deg %0d, field_x %0d",
                       got.heading_deg, got.field_x);
                errors++;
                return;
            end
            e = owed_headings.pop_front();
            compare_field("heading_ok", e.heading_ok, got.heading_ok);
            // one lsb either way is allowed on a real angle, also across the wrap
            diff = int'(got.heading_deg) - int'(e.heading_deg);
            near = e.heading_ok && (e.field_x != 0 || e.field_y != 0) &&
                   !$isunknown(got.heading_deg) &&
                   (diff == 1 || diff == -1 || diff == FULL_TURN - 1 ||
                    diff == -(FULL_TURN - 1));
            if (!near) begin
                compare_field("heading_deg", e.heading_deg, got.heading_deg);
            end
            compare_field("field_x", e.field_x, got.field_x);
            compare_field("field_y", e.field_y, got.field_y);
            compare_field("field_z", e.field_z, got.field_z);
        endfunction

        function int pending();
            return owed_headings.size();
        endfunction

        function int close_out();
            if (owed_headings.size() != 0) begin
                $error("%0d results never arrived", owed_headings.size());
                errors++;
            end
            return errors;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    bit   hold_off_req = 1'b0;
    int   idle_cycles  = 0;

    heading_tracker tracker = new();

    mh_req_if req_if();
    mh_res_if res_if();

    magnetometer_heading dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    always #5 i_clk = ~i_clk;

    // result monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            tracker.check_heading(res_if.data);
        end
        if (!i_rst_n || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 60);
    endfunction

    function automatic logic signed [FIELD_W-1:0] pick_axis();
        case ($urandom_range(0, 7))
            0, 1, 2: return FIELD_W'($urandom);
            3:       return FIELD_W'($urandom_range(0, 16)) - 16'sd8;
            4: begin
                case ($urandom_range(0, 4))
                    0:       return 16'sh8000;
                    1:       return 16'sh7FFF;
                    2:       return -16'sd1;
                    3:       return 16'sd1;
                    default: return 16'sd0;
                endcase
            end
            5:       return FIELD_W'($urandom_range(0, 2000)) - 16'sd1000;
            6:       return 16'sd0;
            default: return FIELD_W'($urandom_range(0, 255)) <<< $urandom_range(0, 8);
        endcase
    endfunction

    function automatic t_mh_req make_read(bit complete, logic signed [FIELD_W-1:0] x,
                                          logic signed [FIELD_W-1:0] y,
                                          logic signed [FIELD_W-1:0] z);
        t_mh_req r;
        r.read_complete = complete;
        {r.x_high, r.x_low} = x;
        {r.z_high, r.z_low} = z;
        {r.y_high, r.y_low} = y;
        return r;
    endfunction

    function automatic t_mh_req random_read();
        if ($urandom_range(0, 99) < 15) begin
            return make_read(1'b0, FIELD_W'($urandom), FIELD_W'($urandom),
                             FIELD_W'($urandom));
        end
        return make_read(1'b1, pick_axis(), pick_axis(), pick_axis());
    endfunction

    // offer one request, hold it until taken, then optionally go idle
    task automatic send_read(t_mh_req r, int gap);
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge i_clk);
        while (!(req_if.valid && req_if.ready)) @(posedge i_clk);
        tracker.note_read(r);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending() != 0);
    endtask

    // receiver: random stalls, bursts of ready, one long hold-off
    initial begin
        int burst;
        int stall;
        res_if.ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
            end else begin
                burst = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 4);
                res_if.ready <= 1'b1;
                repeat (burst) @(posedge i_clk);
                stall = pick_gap();
                if (stall > 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
        end
    end

    // sender: directed reads, then random ones
    initial begin
        int burst;
        int gap;
        burst = 0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero vector from reset, the four axes, corners and full-scale values
        send_read(make_read(1'b1, 16'sd0, 16'sd0, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sd1000, 16'sd0, 16'sd5), pick_gap());
        send_read(make_read(1'b1, 16'sd0, 16'sd1000, -16'sd5), pick_gap());
        send_read(make_read(1'b1, -16'sd1000, 16'sd0, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sd0, -16'sd1000, 16'sd0), pick_gap());
        // just below a full turn, rounds up to 360 and wraps to 0
        send_read(make_read(1'b1, 16'sh7FFF, -16'sd1, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sh8000, 16'sh8000, 16'sh7FFF), pick_gap());
        send_read(make_read(1'b1, 16'sh7FFF, 16'sh7FFF, 16'sh8000), pick_gap());
        send_read(make_read(1'b1, 16'sh8000, 16'sh7FFF, 16'sh7FFF), pick_gap());
        send_read(make_read(1'b1, 16'sh7FFF, 16'sh8000, -16'sd1), pick_gap());
        send_read(make_read(1'b1, -16'sd1, -16'sd1, -16'sd1), pick_gap());
        send_read(make_read(1'b1, 16'sh8000, 16'sd0, 16'sd1), pick_gap());
        send_read(make_read(1'b1, 16'sh8000, 16'sd1, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sh8000, -16'sd1, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sd1, 16'sd1, 16'sd0), pick_gap());
        send_read(make_read(1'b1, -16'sd1, 16'sd0, 16'sd0), pick_gap());
        // incomplete reads keep the stored fields
        send_read(make_read(1'b0, -16'sd1, -16'sd1, -16'sd1), pick_gap());
        send_read(make_read(1'b0, 16'sd0, 16'sd0, 16'sd0), pick_gap());
        send_read(make_read(1'b1, 16'sd0, 16'sd0, 16'sh1234), pick_gap());
        send_read(make_read(1'b0, 16'sh5A5A, 16'shA5A5, 16'sh0F0F), pick_gap());
        send_read(make_read(1'b1, 16'sd3, -16'sd4, 16'sh8000), 0);
        send_read(make_read(1'b0, 16'shFF00, 16'sh00FF, 16'shF0F0), 0);

        for (int n = 0; n < RANDOM_READS; n++) begin
            // receiver blocks for a while as requests keep coming
            if (n == 600) begin
                hold_off_req = 1'b1;
                burst = 40;
            end
            // sender pauses until the block has drained
            if (n == 1200) wait_drained();
            if (n % 250 == 0 && burst == 0) burst = 30;
            if (burst > 0) begin
                gap = 0;
                burst--;
            end else begin
                gap = pick_gap();
            end
            send_read(random_read(), gap);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.close_out() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
